@@ design/ocrms_pkg.sv @@
package ocrms_pkg;

  // Default frame length in sample pairs
  localparam int unsigned SAMPLES_DEF = 40;

  // Width of the sum-of-squares accumulators
  localparam int unsigned SUM_W = 42;

  // Limit register width
  localparam int unsigned LIMIT_W = 32;

  // Reset values of the limit registers
  localparam logic [LIMIT_W-1:0] PHASE_LIMIT_RST   = 32'd3824;
  localparam logic [LIMIT_W-1:0] NEUTRAL_LIMIT_RST = 32'd32397;

  // Result queue depth, also the number of outstanding results before stalling
  localparam int unsigned RES_DEPTH = 8;

  // Input command codes
  typedef enum logic {
    CMD_MEASURE = 1'b0,
    CMD_CAPTURE = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_PHASE_LIMIT   = 1'b0,
    CFG_NEUTRAL_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] phase_sample;
    logic signed [15:0] neutral_sample;
    logic               frame_end;
  } in_item_t;

  typedef struct packed {
    logic phase_present;
    logic neutral_present;
  } out_item_t;

endpackage

@@ design/offset_compensated_rms_current_detect_unit.sv @@
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   in_data_i   (ocrms_pkg::in_item_t)
// out       source     out_valid_o / out_stall_i out_data_o  (ocrms_pkg::out_item_t)
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One sample pair is taken every cycle while in_stall_o is low. The offset
// store is read once per request, and written on capture requests, through a
// single port with a registered read, and the per-frame arithmetic runs in four
// more register stages before a result can leave the block.
// Results wait in an eight-entry queue; in_stall_o rises only once eight
// results are outstanding (in flight or queued) and out_stall_i holds them.
// Reset clears the frame position, the sums and the per-entry valid bits of
// the offset store at once; no clearing pass is needed.
module offset_compensated_rms_current_detect_unit #(
  parameter int unsigned SAMPLES = ocrms_pkg::SAMPLES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Sample requests
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  ocrms_pkg::in_item_t                  in_data_i,
  // Presence results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output ocrms_pkg::out_item_t                 out_data_o,
  // Limit register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  ocrms_pkg::cfg_idx_e                  cfg_index_i,
  input  logic [ocrms_pkg::LIMIT_W-1:0]        cfg_data_i
);
  import ocrms_pkg::*;

  localparam int unsigned POS_W  = (SAMPLES > 2) ? $clog2(SAMPLES) : 1;
  localparam int unsigned PROD_W = LIMIT_W + 1 + POS_W;
  localparam int unsigned QPTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CRED_W = $clog2(RES_DEPTH + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES - 1);

  typedef struct packed {
    logic signed [15:0] phase;
    logic signed [15:0] neutral;
  } ofs_word_t;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0] ph_limit_q, nu_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_limit_q <= PHASE_LIMIT_RST;
      nu_limit_q <= NEUTRAL_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PHASE_LIMIT:   ph_limit_q <= cfg_data_i;
        CFG_NEUTRAL_LIMIT: nu_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: frame position, offset store access
  // ---------------------------------------------------------------------------
  logic               in_acc;
  logic               is_capture;
  logic               is_result;
  logic               pos_summed;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [SAMPLES-1:0] ofs_vld_q;
  ofs_word_t          ofs_mem [SAMPLES];
  ofs_word_t          rd_q;

  logic [CRED_W-1:0]  cred_q;
  logic               out_acc;

  assign in_stall_o = (cred_q == CRED_W'(RES_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_capture = (in_data_i.cmd == CMD_CAPTURE);
  assign is_result  = !is_capture && in_data_i.frame_end;
  // The last position of a frame is never summed; an overlong frame stays on it
  assign pos_summed = (pos_q != POS_LAST);

  always_comb begin
    pos_d = pos_q;
    if (in_data_i.frame_end) begin
      pos_d = '0;
    end else if (pos_summed) begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ofs_vld_q <= '0;
    end else if (in_acc) begin
      pos_q <= pos_d;
      if (is_capture) begin
        ofs_vld_q[pos_q] <= 1'b1;
      end
    end
  end

  // Capture writes at the accept edge, so a following request already reads
  // the new offset: no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (is_capture) begin
        ofs_mem[pos_q] <= '{phase: in_data_i.phase_sample,
                            neutral: in_data_i.neutral_sample};
      end
      rd_q <= ofs_mem[pos_q];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: subtract offset, square
  // ---------------------------------------------------------------------------
  logic               s1_vld_q;
  logic               s1_add_q, s1_fend_q, s1_res_q, s1_ofs_ok_q;
  logic signed [15:0] s1_ph_q, s1_nu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_add_q    <= !is_capture && pos_summed;
      s1_fend_q   <= in_data_i.frame_end;
      s1_res_q    <= is_result;
      s1_ofs_ok_q <= ofs_vld_q[pos_q];
      s1_ph_q     <= in_data_i.phase_sample;
      s1_nu_q     <= in_data_i.neutral_sample;
    end
  end

  logic signed [15:0] ofs_ph, ofs_nu;
  logic signed [16:0] ph_diff, nu_diff;
  logic [16:0]        ph_abs, nu_abs;
  logic [15:0]        ph_mag, nu_mag;
  logic [31:0]        ph_sq, nu_sq;

  // An entry never captured since reset reads as zero
  assign ofs_ph  = s1_ofs_ok_q ? rd_q.phase   : 16'sd0;
  assign ofs_nu  = s1_ofs_ok_q ? rd_q.neutral : 16'sd0;
  assign ph_diff = $signed({s1_ph_q[15], s1_ph_q}) - $signed({ofs_ph[15], ofs_ph});
  assign nu_diff = $signed({s1_nu_q[15], s1_nu_q}) - $signed({ofs_nu[15], ofs_nu});
  assign ph_abs  = ph_diff[16] ? 17'(-ph_diff) : 17'(ph_diff);
  assign nu_abs  = nu_diff[16] ? 17'(-nu_diff) : 17'(nu_diff);
  assign ph_mag  = ph_abs[15:0];
  assign nu_mag  = nu_abs[15:0];
  assign ph_sq   = ph_mag * ph_mag;
  assign nu_sq   = nu_mag * nu_mag;

  // ---------------------------------------------------------------------------
  // Stage 2: accumulate, close the frame
  // ---------------------------------------------------------------------------
  logic             s2_vld_q;
  logic             s2_add_q, s2_fend_q, s2_res_q;
  logic [31:0]      s2_ph_sq_q, s2_nu_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_add_q   <= s1_add_q;
      s2_fend_q  <= s1_fend_q;
      s2_res_q   <= s1_res_q;
      s2_ph_sq_q <= ph_sq;
      s2_nu_sq_q <= nu_sq;
    end
  end

  logic [SUM_W-1:0] ph_sum_q, nu_sum_q, ph_sum_d, nu_sum_d;
  logic [POS_W-1:0] cnt_q, cnt_d;

  assign ph_sum_d = ph_sum_q + (s2_add_q ? SUM_W'(s2_ph_sq_q) : '0);
  assign nu_sum_d = nu_sum_q + (s2_add_q ? SUM_W'(s2_nu_sq_q) : '0);
  assign cnt_d    = cnt_q + POS_W'(s2_add_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_sum_q <= '0;
      nu_sum_q <= '0;
      cnt_q    <= '0;
    end else if (s2_vld_q) begin
      if (s2_fend_q) begin
        ph_sum_q <= '0;
        nu_sum_q <= '0;
        cnt_q    <= '0;
      end else begin
        ph_sum_q <= ph_sum_d;
        nu_sum_q <= nu_sum_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale limits by the count
  // floor(sum / count) > limit  <=>  sum >= (limit + 1) * count
  // ---------------------------------------------------------------------------
  logic             s3_vld_q;
  logic [SUM_W-1:0] s3_ph_sum_q, s3_nu_sum_q;
  logic [POS_W-1:0] s3_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q && s2_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && s2_res_q) begin
      s3_ph_sum_q <= ph_sum_d;
      s3_nu_sum_q <= nu_sum_d;
      s3_cnt_q    <= cnt_d;
    end
  end

  logic [LIMIT_W:0] ph_lim_inc, nu_lim_inc;
  logic [PROD_W-1:0] ph_prod, nu_prod;

  assign ph_lim_inc = {1'b0, ph_limit_q} + (LIMIT_W+1)'(1);
  assign nu_lim_inc = {1'b0, nu_limit_q} + (LIMIT_W+1)'(1);
  assign ph_prod    = PROD_W'(ph_lim_inc) * PROD_W'(s3_cnt_q);
  assign nu_prod    = PROD_W'(nu_lim_inc) * PROD_W'(s3_cnt_q);

  // ---------------------------------------------------------------------------
  // Stage 4: compare
  // ---------------------------------------------------------------------------
  logic              s4_vld_q;
  logic              s4_nz_q;
  logic [SUM_W-1:0]  s4_ph_sum_q, s4_nu_sum_q;
  logic [PROD_W-1:0] s4_ph_prod_q, s4_nu_prod_q;
  out_item_t         res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      s4_nz_q      <= (s3_cnt_q != '0);
      s4_ph_sum_q  <= s3_ph_sum_q;
      s4_nu_sum_q  <= s3_nu_sum_q;
      s4_ph_prod_q <= ph_prod;
      s4_nu_prod_q <= nu_prod;
    end
  end

  // An empty sum reports no current on either channel
  assign res.phase_present   = s4_nz_q && (s4_ph_sum_q >= SUM_W'(s4_ph_prod_q));
  assign res.neutral_present = s4_nz_q && (s4_nu_sum_q >= SUM_W'(s4_nu_prod_q));

  // ---------------------------------------------------------------------------
  // Result queue and outstanding-result credit
  // ---------------------------------------------------------------------------
  out_item_t         rq_q [RES_DEPTH];
  logic [QPTR_W-1:0] rq_wr_q, rq_rd_q;
  logic [CRED_W-1:0] rq_cnt_q;

  assign out_valid_o = (rq_cnt_q != '0);
  assign out_data_o  = rq_q[rq_rd_q];
  assign out_acc     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (s4_vld_q) begin
      rq_q[rq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
      cred_q   <= '0;
    end else begin
      if (s4_vld_q) begin
        rq_wr_q <= rq_wr_q + QPTR_W'(1);
      end
      if (out_acc) begin
        rq_rd_q <= rq_rd_q + QPTR_W'(1);
      end
      rq_cnt_q <= rq_cnt_q + CRED_W'(s4_vld_q) - CRED_W'(out_acc);
      // Reserve a queue slot for every result-producing request taken
      cred_q   <= cred_q + CRED_W'(in_acc && is_result) - CRED_W'(out_acc);
    end
  end

endmodule

@@ design/ocrms_chk.sv @@
module ocrms_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input ocrms_pkg::in_item_t          in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input ocrms_pkg::out_item_t         out_data_o
);
  import ocrms_pkg::*;

  logic [7:0] pend_q;
  logic       in_res, out_acc;

  assign in_res  = in_valid_i && !in_stall_o && (in_data_i.cmd == CMD_MEASURE)
                   && in_data_i.frame_end;
  assign out_acc = out_valid_o && !out_stall_i;

  // Track frame results requested but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_res) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 8'd0)
    else $error("result without a frame-end measure request");

  a_stall_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pend_q != 8'd0)
    else $error("input stalled with no results outstanding");

endmodule

bind offset_compensated_rms_current_detect_unit ocrms_chk u_ocrms_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
